@@ rtl/spas_pkg.sv @@
// ----------------------------------------------------------------------------
// spas_pkg: shared types and constants of the servo PID angle step block
// Field widths, register indexes and the control program of the sequencer.
// ----------------------------------------------------------------------------
package spas_pkg;

   // Field and datapath widths
   localparam int DT_W        = 16;
   localparam int ANGLE_W     = 8;
   localparam int GAIN_W      = 16;
   localparam int DRIVE_W     = 16;
   localparam int ERR_W       = 10;  // set point minus angle: -180..255
   localparam int SUM_W       = 11;  // error sum or difference
   localparam int DIFF_MAG_W  = 9;   // |error difference| <= 435
   localparam int DERIV_FRAC  = 8;
   localparam int DIV_W       = DIFF_MAG_W + DERIV_FRAC;
   localparam int DIV_CNT_W   = $clog2(DIV_W);
   localparam int DERIV_W     = DIV_W + 1;
   localparam int INTEG_W     = 40;
   localparam int INTEG_SPLIT = 24;
   localparam int MUL_A_W     = GAIN_W + 1;
   localparam int MUL_B_W     = INTEG_SPLIT + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int ACC_W       = 64;
   localparam int ANGLE_MAX   = 180;

   // Term alignment: every term carries gain fraction bits + 8
   localparam int SHIFT_P     = 8;
   localparam int SHIFT_ILO   = 7;
   localparam int SHIFT_IHI   = INTEG_SPLIT + SHIFT_ILO;
   localparam int SHIFT_D     = 0;

   localparam int GAIN_FRAC_BITS_DEF = 8;

   // Stream and register port widths
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SET_POINT = 2'd0,
      CSR_GAIN_P    = 2'd1,
      CSR_GAIN_I    = 2'd2,
      CSR_GAIN_D    = 2'd3
   } csr_index_type;

   // Sequencer program
   localparam int PC_W = 3;

   localparam logic [PC_W-1:0] STEP_LOAD   = 3'd0;
   localparam logic [PC_W-1:0] STEP_DIV    = 3'd1;
   localparam logic [PC_W-1:0] STEP_UPDATE = 3'd2;
   localparam logic [PC_W-1:0] STEP_ACC_P  = 3'd3;
   localparam logic [PC_W-1:0] STEP_ACC_IL = 3'd4;
   localparam logic [PC_W-1:0] STEP_ACC_IH = 3'd5;
   localparam logic [PC_W-1:0] STEP_ACC_D  = 3'd6;
   localparam logic [PC_W-1:0] STEP_FINISH = 3'd7;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,     // take an item, waits for one
      OP_DIV,      // one restoring divide step
      OP_UPDATE,   // derivative and integral update
      OP_FINISH    // drive, angle and result, waits for a free output
   } op_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_IDT,     // error sum * dt
      MUL_P,       // gain_p * error
      MUL_ILO,     // gain_i * integral low part
      MUL_IHI,     // gain_i * integral high part
      MUL_D        // gain_d * derivative
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ADD_P,
      ACC_ADD_ILO,
      ACC_ADD_IHI,
      ACC_ADD_D
   } acc_sel_type;

   typedef enum logic [1:0] {
      JC_NONE,
      JC_ALWAYS,
      JC_DIV_BUSY
   } jcond_type;

   typedef struct packed {
      op_type          op;
      mul_sel_type     mul;
      acc_sel_type     acc;
      jcond_type       jc;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   // Control store
   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{op: OP_NOP, mul: MUL_NONE, acc: ACC_HOLD, jc: JC_NONE, target: STEP_LOAD};
      unique case (pc)
         STEP_LOAD:   w = '{OP_LOAD,   MUL_NONE, ACC_HOLD,    JC_NONE,     STEP_LOAD};
         STEP_DIV:    w = '{OP_DIV,    MUL_IDT,  ACC_HOLD,    JC_DIV_BUSY, STEP_DIV};
         STEP_UPDATE: w = '{OP_UPDATE, MUL_P,    ACC_CLEAR,   JC_NONE,     STEP_LOAD};
         STEP_ACC_P:  w = '{OP_NOP,    MUL_ILO,  ACC_ADD_P,   JC_NONE,     STEP_LOAD};
         STEP_ACC_IL: w = '{OP_NOP,    MUL_IHI,  ACC_ADD_ILO, JC_NONE,     STEP_LOAD};
         STEP_ACC_IH: w = '{OP_NOP,    MUL_D,    ACC_ADD_IHI, JC_NONE,     STEP_LOAD};
         STEP_ACC_D:  w = '{OP_NOP,    MUL_NONE, ACC_ADD_D,   JC_NONE,     STEP_LOAD};
         STEP_FINISH: w = '{OP_FINISH, MUL_NONE, ACC_HOLD,    JC_ALWAYS,   STEP_LOAD};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/servo_pid_angle_step_top.sv @@
// ----------------------------------------------------------------------------
// servo_pid_angle_step_top: PID servo angle controller, one tick per item
// An item runs through the load step, the 17-step restoring divider of the
// derivative, an update step, four product steps on the shared 17x25
// multiplier and the finish step; a new item is taken only after the finish
// step, and a stalled result holds the finish step.
// Reset (synchronous, active high) clears kept state and output valid, loads defaults.
// ----------------------------------------------------------------------------
module servo_pid_angle_step_top #(
   parameter int GAIN_FRAC_BITS = spas_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request: [15:0] elapsed_ms, [16] recalibrate
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [spas_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // response: [7:0] servo_angle, [23:8] drive, [24] turn_clockwise, [25] dt_zero
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [spas_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // register writes
   input  logic                                  csr_we,
   input  logic [spas_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [spas_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import spas_pkg::*;

   localparam int SUM_SHIFT = GAIN_FRAC_BITS + 8;

   // Sequencer
   logic [PC_W-1:0]           pc_ff, pc_in;
   ctrl_word_type             ctrl;

   // Registers
   logic [ANGLE_W-1:0]        set_point_ff;
   logic signed [GAIN_W-1:0]  gain_p_ff, gain_i_ff, gain_d_ff;

   // Kept state
   logic [ANGLE_W-1:0]        angle_ff, angle_in;
   logic signed [ERR_W-1:0]   last_err_ff;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [DERIV_W-1:0] deriv_ff, deriv_in;

   // Item working registers
   logic [DT_W-1:0]           dt_ff;
   logic                      dtz_ff;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [SUM_W-1:0]   tsum_ff;
   logic                      dneg_ff;
   logic [DIV_W-1:0]          quo_ff, quo_in;
   logic [DT_W-1:0]           rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]      div_cnt_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;

   // Output register
   logic                      rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0]    rsp_tdata_ff, rsp_tdata_in;

   logic                      req_accept;
   logic                      out_free;
   logic                      do_finish;

   // Load step: error and divide setup
   logic                      recal;
   logic [ANGLE_W-1:0]        angle_eff;
   logic signed [ERR_W-1:0]   err_new;
   logic signed [SUM_W-1:0]   diff_w, diff_mag, tsum_new;
   logic [DIV_W-1:0]          dividend;

   // Divide step
   logic [DT_W:0]             rem_shift;
   logic                      div_ge;
   logic [DT_W:0]             rem_sub;

   // Multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_prod;
   logic signed [ACC_W-1:0]   prod_ext;

   // Integral saturation
   logic signed [PROD_W-1:0]  integ_sum;

   // Finish step
   logic                      sum_neg;
   logic [ACC_W-1:0]          sum_mag, q_mag;
   logic                      q_big;
   logic signed [DRIVE_W-1:0] drive;
   logic signed [DRIVE_W:0]   angle_sum;

   assign ctrl       = ucode_rom(pc_ff);
   assign req_tready = (ctrl.op == OP_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign do_finish  = (ctrl.op == OP_FINISH) && out_free;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Next step: wait steps hold, otherwise jump or fall through
   always_comb begin
      pc_in = pc_ff + 1'b1;
      if ((ctrl.op == OP_LOAD && !req_tvalid) || (ctrl.op == OP_FINISH && !out_free)) begin
         pc_in = pc_ff;
      end else begin
         unique case (ctrl.jc)
            JC_NONE:     pc_in = pc_ff + 1'b1;
            JC_ALWAYS:   pc_in = ctrl.target;
            JC_DIV_BUSY: pc_in = (div_cnt_ff != '0) ? ctrl.target : pc_ff + 1'b1;
         endcase
      end
   end

   // Error terms of a new item
   always_comb begin
      recal     = req_tdata[DT_W];
      angle_eff = recal ? '0 : angle_ff;
      err_new   = signed'({2'b00, set_point_ff}) - signed'({2'b00, angle_eff});
      diff_w    = SUM_W'(err_new) - SUM_W'(last_err_ff);
      tsum_new  = SUM_W'(err_new) + SUM_W'(last_err_ff);
      diff_mag  = diff_w[SUM_W-1] ? -diff_w : diff_w;
      dividend  = {diff_mag[DIFF_MAG_W-1:0], {DERIV_FRAC{1'b0}}};
   end

   // Restoring divide step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_W-1]};
      div_ge    = rem_shift >= {1'b0, dt_ff};
      rem_sub   = rem_shift - {1'b0, dt_ff};
      rem_in    = div_ge ? rem_sub[DT_W-1:0] : rem_shift[DT_W-1:0];
      quo_in    = {quo_ff[DIV_W-2:0], div_ge};
   end

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctrl.mul)
         MUL_NONE: begin
            mul_a = '0;
            mul_b = '0;
         end
         MUL_IDT: begin
            mul_a = signed'({1'b0, dt_ff});
            mul_b = MUL_B_W'(tsum_ff);
         end
         MUL_P: begin
            mul_a = MUL_A_W'(gain_p_ff);
            mul_b = MUL_B_W'(err_ff);
         end
         MUL_ILO: begin
            mul_a = MUL_A_W'(gain_i_ff);
            mul_b = signed'({1'b0, integ_ff[INTEG_SPLIT-1:0]});
         end
         MUL_IHI: begin
            mul_a = MUL_A_W'(gain_i_ff);
            mul_b = MUL_B_W'(signed'(integ_ff[INTEG_W-1:INTEG_SPLIT]));
         end
         MUL_D: begin
            mul_a = MUL_A_W'(gain_d_ff);
            mul_b = MUL_B_W'(deriv_ff);
         end
      endcase
   end

   assign mul_prod = mul_a * mul_b;
   assign prod_ext = ACC_W'(prod_ff);

   // Term accumulator
   always_comb begin
      acc_in = acc_ff;
      unique case (ctrl.acc)
         ACC_HOLD:    acc_in = acc_ff;
         ACC_CLEAR:   acc_in = '0;
         ACC_ADD_P:   acc_in = acc_ff + (prod_ext <<< SHIFT_P);
         ACC_ADD_ILO: acc_in = acc_ff + (prod_ext <<< SHIFT_ILO);
         ACC_ADD_IHI: acc_in = acc_ff + (prod_ext <<< SHIFT_IHI);
         ACC_ADD_D:   acc_in = acc_ff + (prod_ext <<< SHIFT_D);
      endcase
   end

   // Derivative and saturating integral
   always_comb begin
      deriv_in  = dneg_ff ? -signed'({1'b0, quo_ff}) : signed'({1'b0, quo_ff});
      integ_sum = PROD_W'(integ_ff) + prod_ff;
      if (integ_sum[PROD_W-1:INTEG_W-1] == '0 || integ_sum[PROD_W-1:INTEG_W-1] == '1) begin
         integ_in = integ_sum[INTEG_W-1:0];
      end else begin
         integ_in = integ_sum[PROD_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                        : {1'b0, {(INTEG_W-1){1'b1}}};
      end
   end

   // Drive: truncate toward zero, saturate; new angle
   always_comb begin
      sum_neg = acc_ff[ACC_W-1];
      sum_mag = sum_neg ? unsigned'(-acc_ff) : unsigned'(acc_ff);
      q_mag   = sum_mag >> SUM_SHIFT;
      q_big   = |q_mag[ACC_W-1:DRIVE_W-1];
      if (sum_neg) begin
         drive = q_big ? {1'b1, {(DRIVE_W-1){1'b0}}} : -signed'(q_mag[DRIVE_W-1:0]);
      end else begin
         drive = q_big ? {1'b0, {(DRIVE_W-1){1'b1}}} : signed'(q_mag[DRIVE_W-1:0]);
      end
      angle_sum = signed'({{(DRIVE_W+1-ANGLE_W){1'b0}}, angle_ff}) + (DRIVE_W+1)'(drive);
      if (angle_sum < 0) begin
         angle_in = '0;
      end else if (angle_sum > ANGLE_MAX) begin
         angle_in = ANGLE_W'(ANGLE_MAX);
      end else begin
         angle_in = angle_sum[ANGLE_W-1:0];
      end
      rsp_tdata_in = RSP_TDATA_W'({dtz_ff, drive[DRIVE_W-1], drive, angle_in});
   end

   // Control, registers and kept state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= STEP_LOAD;
         rsp_tvalid_ff <= 1'b0;
         set_point_ff  <= '0;
         gain_p_ff     <= 16'sd256;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         angle_ff      <= '0;
         last_err_ff   <= '0;
         integ_ff      <= '0;
         deriv_ff      <= '0;
         div_cnt_ff    <= '0;
      end else begin
         pc_ff <= pc_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_SET_POINT: set_point_ff <= csr_wdata[ANGLE_W-1:0];
               CSR_GAIN_P:    gain_p_ff    <= signed'(csr_wdata);
               CSR_GAIN_I:    gain_i_ff    <= signed'(csr_wdata);
               CSR_GAIN_D:    gain_d_ff    <= signed'(csr_wdata);
            endcase
         end
         if (req_accept) begin
            div_cnt_ff <= DIV_CNT_W'(DIV_W - 1);
            if (recal) begin
               angle_ff <= '0;
               deriv_ff <= '0;
            end
         end else if (ctrl.op == OP_DIV && div_cnt_ff != '0) begin
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
         if (ctrl.op == OP_UPDATE) begin
            integ_ff <= integ_in;
            if (!dtz_ff) begin
               deriv_ff <= deriv_in;
            end
         end
         if (do_finish) begin
            angle_ff      <= angle_in;
            last_err_ff   <= err_ff;
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Datapath payload
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctrl.mul != MUL_NONE) begin
         prod_ff <= mul_prod;
      end
      if (req_accept) begin
         dt_ff   <= req_tdata[DT_W-1:0];
         dtz_ff  <= (req_tdata[DT_W-1:0] == '0);
         err_ff  <= err_new;
         tsum_ff <= tsum_new;
         dneg_ff <= diff_w[SUM_W-1];
         quo_ff  <= dividend;
         rem_ff  <= '0;
      end else if (ctrl.op == OP_DIV) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (do_finish) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   // Checks
   a_accept_to_div: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> pc_ff == STEP_DIV)
      else $error("accepted item did not enter the divide loop");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      pc_ff == STEP_UPDATE |-> div_cnt_ff == '0)
      else $error("derivative update before the divide finished");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      angle_ff <= ANGLE_W'(ANGLE_MAX))
      else $error("kept angle out of range");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(pc_ff) == STEP_FINISH)
      else $error("result raised outside the finish step");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("second item taken while one is in work");

endmodule
